[hw/rtl/barometric_pressure_compensation_defines.svh]
// Assertion helpers shared by the pressure compensation RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpc_pkg.sv]
`default_nettype none

package bpc_pkg;

    // Temperature thresholds in 0.01 degC
    localparam int TEMP_REF      = 2000;
    localparam int TEMP_VERY_LOW = -1500;

    // Calibration register map (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

    // Factory calibration words
    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } cal_t;

    // Beat handed from the temperature front end to the pressure back end
    typedef struct packed {
        logic        [23:0] d1;      // raw pressure
        logic signed [20:0] temp_c;  // temperature after second-order term
        logic        [35:0] a2;      // (TEMP - 2000)^2
        logic        [35:0] b2;      // (TEMP + 1500)^2
        logic               lt_ref;  // TEMP below 20.00 degC
        logic               lt_low;  // TEMP below -15.00 degC
        logic signed [35:0] off;     // first-order offset
        logic signed [35:0] sens;    // first-order sensitivity
    } front_t;

endpackage

`default_nettype wire

[hw/rtl/bpc_regs.sv]
`default_nettype none

module bpc_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output bpc_pkg::cal_t         cal
);

    bpc_pkg::cal_t     cal_reg;
    bpc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = bpc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    // Register writes; indexes past the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                bpc_pkg::REG_C1: cal_reg.c1 <= pwdata[15:0];
                bpc_pkg::REG_C2: cal_reg.c2 <= pwdata[15:0];
                bpc_pkg::REG_C3: cal_reg.c3 <= pwdata[15:0];
                bpc_pkg::REG_C4: cal_reg.c4 <= pwdata[15:0];
                bpc_pkg::REG_C5: cal_reg.c5 <= pwdata[15:0];
                bpc_pkg::REG_C6: cal_reg.c6 <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            bpc_pkg::REG_C1: prdata = {16'h0000, cal_reg.c1};
            bpc_pkg::REG_C2: prdata = {16'h0000, cal_reg.c2};
            bpc_pkg::REG_C3: prdata = {16'h0000, cal_reg.c3};
            bpc_pkg::REG_C4: prdata = {16'h0000, cal_reg.c4};
            bpc_pkg::REG_C5: prdata = {16'h0000, cal_reg.c5};
            bpc_pkg::REG_C6: prdata = {16'h0000, cal_reg.c6};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bpc_front.sv]
`default_nettype none
`include "barometric_pressure_compensation_defines.svh"

// Stages 1-4: dT, first-order products, TEMP/OFF/SENS, squares for the
// second-order correction.
module bpc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bpc_pkg::cal_t    cal,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire logic [23:0]      raw_temperature,
    input  wire logic [23:0]      raw_pressure,
    input  wire logic             down_en,
    output logic                  front_valid,
    output bpc_pkg::front_t       front_data
);

    // Per-stage advance; a stage moves when empty or when the next one moves
    logic en1, en2, en3, en4;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;

    assign en4 = !s4_vld_reg || down_en;
    assign en3 = !s3_vld_reg || en4;
    assign en2 = !s2_vld_reg || en3;
    assign en1 = !s1_vld_reg || en2;
    assign sample_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_vld_reg <= sample_valid;
            if (en2) s2_vld_reg <= s1_vld_reg;
            if (en3) s3_vld_reg <= s2_vld_reg;
            if (en4) s4_vld_reg <= s3_vld_reg;
        end
    end

    // Stage 1: dT = D2 - C5 * 256
    logic signed [24:0] s1_dt_next, s1_dt_reg;
    logic        [23:0] s1_d1_reg;

    assign s1_dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_dt_reg <= s1_dt_next;
            s1_d1_reg <= raw_pressure;
        end
    end

    // Stage 2: dT*C6, dT*C4, dT*C3 and dT^2
    logic signed [41:0] s2_ptemp_next, s2_ptemp_reg;
    logic signed [41:0] s2_poff_next, s2_poff_reg;
    logic signed [41:0] s2_psens_next, s2_psens_reg;
    logic signed [49:0] dt_sq;
    logic        [16:0] s2_t2_next, s2_t2_reg;
    logic        [23:0] s2_d1_reg;

    assign s2_ptemp_next = s1_dt_reg * $signed({1'b0, cal.c6});
    assign s2_poff_next  = s1_dt_reg * $signed({1'b0, cal.c4});
    assign s2_psens_next = s1_dt_reg * $signed({1'b0, cal.c3});
    assign dt_sq         = s1_dt_reg * s1_dt_reg;
    // T2 = dT^2 >> 31; dT^2 stays below 2^48
    assign s2_t2_next    = dt_sq[47:31];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_ptemp_reg <= s2_ptemp_next;
            s2_poff_reg  <= s2_poff_next;
            s2_psens_reg <= s2_psens_next;
            s2_t2_reg    <= s2_t2_next;
            s2_d1_reg    <= s1_d1_reg;
        end
    end

    // Stage 3: a = TEMP - 2000, b = TEMP + 1500, OFF, SENS
    logic signed [18:0] s3_a_next, s3_a_reg;
    logic signed [18:0] s3_b_next, s3_b_reg;
    logic signed [35:0] s3_off_next, s3_off_reg;
    logic signed [35:0] s3_sens_next, s3_sens_reg;
    logic        [16:0] s3_t2_reg;
    logic        [23:0] s3_d1_reg;

    assign s3_a_next    = s2_ptemp_reg[41:23];
    assign s3_b_next    = s3_a_next + 19'(bpc_pkg::TEMP_REF - bpc_pkg::TEMP_VERY_LOW);
    assign s3_off_next  = $signed({4'h0, cal.c2, 16'h0000})
                        + $signed({s2_poff_reg[41], s2_poff_reg[41:7]});
    assign s3_sens_next = $signed({5'h00, cal.c1, 15'h0000})
                        + $signed({{2{s2_psens_reg[41]}}, s2_psens_reg[41:8]});

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_a_reg    <= s3_a_next;
            s3_b_reg    <= s3_b_next;
            s3_off_reg  <= s3_off_next;
            s3_sens_reg <= s3_sens_next;
            s3_t2_reg   <= s2_t2_reg;
            s3_d1_reg   <= s2_d1_reg;
        end
    end

    // Stage 4: squares, threshold flags, TEMP - T2
    logic signed [37:0] a_sq, b_sq;
    logic               lt_ref, lt_low;
    bpc_pkg::front_t    s4_data_next, s4_data_reg;

    assign a_sq   = s3_a_reg * s3_a_reg;
    assign b_sq   = s3_b_reg * s3_b_reg;
    assign lt_ref = s3_a_reg[18];
    assign lt_low = s3_b_reg[18];

    always_comb
    begin
        s4_data_next.d1     = s3_d1_reg;
        s4_data_next.temp_c = $signed({{2{s3_a_reg[18]}}, s3_a_reg})
                            + 21'(bpc_pkg::TEMP_REF)
                            - (lt_ref ? $signed({4'h0, s3_t2_reg}) : 21'sd0);
        s4_data_next.a2     = a_sq[35:0];
        s4_data_next.b2     = b_sq[35:0];
        s4_data_next.lt_ref = lt_ref;
        s4_data_next.lt_low = lt_low;
        s4_data_next.off    = s3_off_reg;
        s4_data_next.sens   = s3_sens_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

    assign front_valid = s4_vld_reg;
    assign front_data  = s4_data_reg;

    // Checks
    `BPC_ASSERT_NEXT(a_accept_fills_s1, sample_valid && !sample_stall, s1_vld_reg,
        "accepted sample did not reach stage 1")
    `BPC_ASSERT_NOW(a_low_implies_ref, s4_vld_reg && s4_data_reg.lt_low,
        s4_data_reg.lt_ref, "very-low flag set without low flag")
    `BPC_ASSERT_NOW(a_warm_temp, s4_vld_reg && !s4_data_reg.lt_ref,
        s4_data_reg.temp_c >= 21'(bpc_pkg::TEMP_REF),
        "temperature below reference without second-order flag")

endmodule

`default_nettype wire

[hw/rtl/bpc_back.sv]
`default_nettype none
`include "barometric_pressure_compensation_defines.svh"

// Stages 5-10: OFF2/SENS2, corrected OFF/SENS, split D1*SENS product,
// >>21 and subtract OFF, >>15 with saturation into the output register.
module bpc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              front_valid,
    input  wire bpc_pkg::front_t   front_data,
    output logic                   up_en,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic signed [19:0]     temperature_centideg,
    output logic signed [31:0]     pressure_centimbar
);

    logic en5, en6, en7, en8, en9, en10;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, out_vld_reg;

    assign en10  = !out_vld_reg || !result_stall;
    assign en9   = !s9_vld_reg || en10;
    assign en8   = !s8_vld_reg || en9;
    assign en7   = !s7_vld_reg || en8;
    assign en6   = !s6_vld_reg || en7;
    assign en5   = !s5_vld_reg || en6;
    assign up_en = en5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en5)  s5_vld_reg  <= front_valid;
            if (en6)  s6_vld_reg  <= s5_vld_reg;
            if (en7)  s7_vld_reg  <= s6_vld_reg;
            if (en8)  s8_vld_reg  <= s7_vld_reg;
            if (en9)  s9_vld_reg  <= s8_vld_reg;
            if (en10) out_vld_reg <= s9_vld_reg;
        end
    end

    // Stage 5: OFF2 = 5a^2/2 (+7b^2), SENS2 = 5a^2/4 (+11b^2/2)
    logic        [38:0] a2x5, b2x7;
    logic        [39:0] b2x11;
    logic        [40:0] s5_off2_next, s5_off2_reg;
    logic        [40:0] s5_sens2_next, s5_sens2_reg;
    logic signed [35:0] s5_off_reg, s5_sens_reg;
    logic signed [20:0] s5_temp_reg;
    logic        [23:0] s5_d1_reg;

    assign a2x5  = {3'b000, front_data.a2} + {1'b0, front_data.a2, 2'b00};
    assign b2x7  = {front_data.b2, 3'b000} - {3'b000, front_data.b2};
    assign b2x11 = {1'b0, front_data.b2, 3'b000} + {3'b000, front_data.b2, 1'b0}
                 + {4'h0, front_data.b2};

    always_comb
    begin
        s5_off2_next  = '0;
        s5_sens2_next = '0;
        if (front_data.lt_ref)
        begin
            s5_off2_next  = {3'b000, a2x5[38:1]}
                          + (front_data.lt_low ? {2'b00, b2x7} : 41'd0);
            s5_sens2_next = {4'h0, a2x5[38:2]}
                          + (front_data.lt_low ? {2'b00, b2x11[39:1]} : 41'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;
            s5_off_reg   <= front_data.off;
            s5_sens_reg  <= front_data.sens;
            s5_temp_reg  <= front_data.temp_c;
            s5_d1_reg    <= front_data.d1;
        end
    end

    // Stage 6: OFF -= OFF2, SENS -= SENS2
    logic signed [41:0] s6_off_next, s6_off_reg;
    logic signed [41:0] s6_sens_next, s6_sens_reg;
    logic signed [20:0] s6_temp_reg;
    logic        [23:0] s6_d1_reg;

    assign s6_off_next  = $signed({{6{s5_off_reg[35]}}, s5_off_reg})
                        - $signed({1'b0, s5_off2_reg});
    assign s6_sens_next = $signed({{6{s5_sens_reg[35]}}, s5_sens_reg})
                        - $signed({1'b0, s5_sens2_reg});

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_off_reg  <= s6_off_next;
            s6_sens_reg <= s6_sens_next;
            s6_temp_reg <= s5_temp_reg;
            s6_d1_reg   <= s5_d1_reg;
        end
    end

    // Stage 7: D1*SENS as two partial products (SENS split at bit 21)
    logic        [44:0] s7_pplo_next, s7_pplo_reg;
    logic signed [45:0] s7_pphi_next, s7_pphi_reg;
    logic signed [41:0] s7_off_reg;
    logic signed [20:0] s7_temp_reg;

    assign s7_pplo_next = s6_d1_reg * s6_sens_reg[20:0];
    assign s7_pphi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[41:21]);

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_pplo_reg <= s7_pplo_next;
            s7_pphi_reg <= s7_pphi_next;
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
        end
    end

    // Stage 8: (D1*SENS) >> 21 = hi + (lo >> 21), exact since lo >= 0
    logic signed [46:0] s8_q_next, s8_q_reg;
    logic signed [41:0] s8_off_reg;
    logic signed [20:0] s8_temp_reg;

    assign s8_q_next = $signed({s7_pphi_reg[45], s7_pphi_reg})
                     + $signed({23'd0, s7_pplo_reg[44:21]});

    always_ff @(posedge clk)
    begin
        if (en8)
        begin
            s8_q_reg    <= s8_q_next;
            s8_off_reg  <= s7_off_reg;
            s8_temp_reg <= s7_temp_reg;
        end
    end

    // Stage 9: subtract OFF
    logic signed [47:0] s9_x_next, s9_x_reg;
    logic signed [20:0] s9_temp_reg;

    assign s9_x_next = $signed({s8_q_reg[46], s8_q_reg})
                     - $signed({{6{s8_off_reg[41]}}, s8_off_reg});

    always_ff @(posedge clk)
    begin
        if (en9)
        begin
            s9_x_reg    <= s9_x_next;
            s9_temp_reg <= s8_temp_reg;
        end
    end

    // Stage 10: >> 15, saturate both results
    logic        [32:0] p_wide;
    logic signed [31:0] press_next, press_reg;
    logic signed [19:0] temp_next, temp_reg;

    assign p_wide = s9_x_reg[47:15];

    always_comb
    begin
        if (p_wide[32] != p_wide[31])
        begin
            press_next = p_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            press_next = p_wide[31:0];
        end

        if (s9_temp_reg[20] != s9_temp_reg[19])
        begin
            temp_next = s9_temp_reg[20] ? 20'sh80000 : 20'sh7FFFF;
        end
        else
        begin
            temp_next = s9_temp_reg[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en10)
        begin
            press_reg <= press_next;
            temp_reg  <= temp_next;
        end
    end

    assign result_valid         = out_vld_reg;
    assign temperature_centideg = temp_reg;
    assign pressure_centimbar   = press_reg;

    // Checks: a full stage that cannot advance keeps its beat
    `BPC_ASSERT_NEXT(a_s5_hold, s5_vld_reg && !en6, s5_vld_reg,
        "stage 5 beat lost under stall")
    `BPC_ASSERT_NEXT(a_s9_hold, s9_vld_reg && !en10, s9_vld_reg && $stable(s9_x_reg),
        "stage 9 beat changed under stall")

endmodule

`default_nettype wire

[hw/rtl/barometric_pressure_compensation.sv]
// Throughput: one sample per cycle; every stage holds its beat under stall
// and bubbles are squeezed out, so the input keeps flowing until all ten
// stages are full.
// Reset (rst_n, async, active low): clears all stage valid flags and sets the
// six calibration registers to zero.
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // calibration register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // sample channel
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire logic [23:0]       raw_temperature,
    input  wire logic [23:0]       raw_pressure,
    // result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic signed [19:0]     temperature_centideg,
    output logic signed [31:0]     pressure_centimbar
);

    bpc_pkg::cal_t   cal;
    bpc_pkg::front_t front_data;
    logic            front_valid;
    logic            up_en;

    // Calibration registers
    bpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // Temperature and first-order terms
    bpc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cal             (cal),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .down_en         (up_en),
        .front_valid     (front_valid),
        .front_data      (front_data)
    );

    // Second-order correction and pressure
    bpc_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .front_valid          (front_valid),
        .front_data           (front_data),
        .up_en                (up_en),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .temperature_centideg (temperature_centideg),
        .pressure_centimbar   (pressure_centimbar)
    );

endmodule

`default_nettype wire
